// ===== design/dcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcs_pkg;

   // Table size and number formats.
   localparam int NUM_DISCS  = 64;
   localparam int FRAC_BITS  = 14;
   localparam int ADDR_W     = $clog2(NUM_DISCS);
   localparam int NORM_SHIFT = 14;

   // Shared iterative units.
   localparam int DIV_W      = 40;
   localparam int DIVISOR_W  = 17;
   localparam int DIV_CNT_W  = $clog2(DIV_W);
   localparam int ROOT_IN_W  = 32;
   localparam int ROOT_W     = 16;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   // Request opcodes; any other code reads.
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [5:0]         slot;
      logic signed [15:0] in_pos_x;
      logic signed [15:0] in_pos_y;
      logic signed [15:0] in_vel_x;
      logic signed [15:0] in_vel_y;
      logic [14:0]        in_radius;
      logic [15:0]        in_mass;
   } dcs_req_type;

   typedef struct packed {
      logic [5:0]         out_slot;
      logic signed [15:0] out_pos_x;
      logic signed [15:0] out_pos_y;
      logic signed [15:0] out_vel_x;
      logic signed [15:0] out_vel_y;
      logic [5:0]         hits;
      logic               wall_hit;
   } dcs_rsp_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic [14:0]        radius;
      logic [15:0]        mass;
   } dcs_entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      dcs_entry_type     data;
   } dcs_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } dcs_rd_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } dcs_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } dcs_div_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [ROOT_IN_W-1:0] radicand;
   } dcs_root_req_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } dcs_root_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SELF,
      S_FETCH,
      S_LOAD,
      S_SQUARE,
      S_DIST,
      S_TEST,
      S_ROOT,
      S_NORM_X,
      S_NORM_Y,
      S_DOT_MUL,
      S_DOT_SUM,
      S_IMPULSE,
      S_AI_GO,
      S_AI,
      S_AJ,
      S_APPLY_I,
      S_APPLY_J,
      S_STORE_J,
      S_DONE
   } dcs_state_type;

   // Saturate a wide signed value to 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -36'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      sat16 = r;
   endfunction

   // Divide by the normal scale, rounding half away from zero.
   function automatic logic signed [21:0] rnd_norm(input logic signed [35:0] v);
      logic [35:0] mag;
      logic [35:0] q;
      mag = v[35] ? 36'(-v) : 36'(v);
      q = (mag + (36'(1) << (NORM_SHIFT - 1))) >> NORM_SHIFT;
      rnd_norm = v[35] ? 22'(-q) : 22'(q);
   endfunction

endpackage

`default_nettype wire

// ===== design/dcs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcs_store (
   input  logic                   clock,
   input  logic                   reset,
   input  dcs_pkg::dcs_wr_type    wr,
   input  dcs_pkg::dcs_rd_type    rd,
   output dcs_pkg::dcs_entry_type rd_data
);
   import dcs_pkg::*;

   dcs_entry_type        mem_ff [NUM_DISCS];
   logic [NUM_DISCS-1:0] valid_ff;
   dcs_entry_type        data_ff;
   logic                 hit_ff;

   // Entry storage with a registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         data_ff <= mem_ff[rd.addr];
      end
   end

   // One valid bit per entry; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd.en) begin
            hit_ff <= valid_ff[rd.addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

`default_nettype wire

// ===== design/dcs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcs_div (
   input  logic                     clock,
   input  logic                     reset,
   input  dcs_pkg::dcs_div_req_type req,
   output dcs_pkg::dcs_div_rsp_type rsp
);
   import dcs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [DIVISOR_W:0]   trial;

   // Restoring division, one quotient bit per cycle. The dividend shifts
   // out of the top of the quotient register as quotient bits shift in.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      trial    = {rem_ff, quo_ff[DIV_W-1]};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(DIV_W - 1);
         quo_in   = req.dividend;
         rem_in   = '0;
         dvs_in   = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = DIVISOR_W'(trial);
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/dcs_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcs_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  dcs_pkg::dcs_root_req_type req,
   output dcs_pkg::dcs_root_rsp_type rsp
);
   import dcs_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] count_ff, count_in;
   logic [ROOT_IN_W-1:0]  rem_ff, rem_in;
   logic [ROOT_IN_W-1:0]  root_ff, root_in;
   logic [ROOT_IN_W-1:0]  bit_ff, bit_in;
   logic [ROOT_IN_W:0]    trial;

   // Integer square root, one result bit per cycle.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      trial    = {1'b0, root_ff} + {1'b0, bit_ff};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = ROOT_CNT_W'(ROOT_W - 1);
         rem_in   = req.radicand;
         root_in  = '0;
         bit_in   = ROOT_IN_W'(1) << (ROOT_IN_W - 2);
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[ROOT_IN_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff[ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== design/disc_collision_step_top.sv =====
// Disc collision table: a store of 64 discs (position, velocity, radius,
// mass) that a request writes, reads or updates.
// Requests enter on req_valid/req_stall; one result per request leaves on
// rsp_valid/rsp_stall. A request is taken when valid is high and stall low.
// The block handles one request at a time; req_stall is high from the
// accepting edge until the result has been loaded into the output register.
// A write goes straight to the result; a read first fetches the entry.
// An update reads its own disc, then for each other disc does one memory
// read and the overlap tests; each impulse applied uses the shared 40-step
// divider four times and the 16-step square root unit once.
// A result waits in the output register while rsp_stall is high; the
// block then accepts the next request but holds its own result until the
// register frees.
// Reset clears the per-entry valid bits at once, so the whole table reads
// as zero right after reset with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module disc_collision_step_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dcs_pkg::dcs_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dcs_pkg::dcs_rsp_type rsp_data
);
   import dcs_pkg::*;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         slot;
      logic [ADDR_W:0]    j;
      logic [5:0]         hits;
      logic               wall;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic [14:0]        r;
      logic [15:0]        mi;
      dcs_entry_type      ej;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [16:0] rvx;
      logic signed [16:0] rvy;
      logic [15:0]        sr;
      logic signed [33:0] dxx;
      logic signed [33:0] dyy;
      logic [31:0]        srr;
      logic [33:0]        d2;
      logic signed [33:0] pxx;
      logic signed [33:0] pyy;
      logic [15:0]        len;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [32:0] tx;
      logic signed [32:0] ty;
      logic signed [18:0] dot;
      logic signed [35:0] prod_i;
      logic signed [35:0] prod_j;
      logic signed [19:0] ai;
      logic signed [19:0] aj;
      logic signed [35:0] qx;
      logic signed [35:0] qy;
   } work_type;

   localparam logic signed [35:0] WALL = 36'sd1 <<< FRAC_BITS;

   dcs_state_type    state_ff, state_in;
   work_type         w_ff, w_in;
   dcs_wr_type       wr;
   dcs_rd_type       rd;
   dcs_entry_type    rd_data;
   dcs_div_req_type  div_req;
   dcs_div_rsp_type  div_rsp;
   dcs_root_req_type root_req;
   dcs_root_rsp_type root_rsp;
   logic             rsp_valid_ff, rsp_valid_in;
   dcs_rsp_type      rsp_data_ff;
   logic             rsp_load;

   // Move and wall reflection of the updated disc.
   logic signed [35:0] rad_s;
   logic signed [15:0] mx, my, mvx, mvy;
   logic               wall_any;
   logic [16:0]        msum;
   logic signed [34:0] approach;

   function automatic logic [16:0] mag17(input logic signed [16:0] v);
      mag17 = v[16] ? 17'(-v) : 17'(v);
   endfunction

   function automatic logic [35:0] mag36(input logic signed [35:0] v);
      mag36 = v[35] ? 36'(-v) : 36'(v);
   endfunction

   dcs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   dcs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   dcs_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (root_req),
      .rsp   (root_rsp)
   );

   // Step and reflect off left, right, bottom and top in turn.
   always_comb begin
      rad_s    = signed'({21'b0, rd_data.radius});
      wall_any = 1'b0;
      mx  = sat16(36'(rd_data.pos_x) + 36'(rd_data.vel_x));
      my  = sat16(36'(rd_data.pos_y) + 36'(rd_data.vel_y));
      mvx = rd_data.vel_x;
      mvy = rd_data.vel_y;
      if (36'(mx) - rad_s < -WALL) begin
         mx = sat16(rad_s - WALL);
         mvx = sat16(-36'(mvx));
         wall_any = 1'b1;
      end
      if (36'(mx) + rad_s > WALL) begin
         mx = sat16(WALL - rad_s);
         mvx = sat16(-36'(mvx));
         wall_any = 1'b1;
      end
      if (36'(my) - rad_s < -WALL) begin
         my = sat16(rad_s - WALL);
         mvy = sat16(-36'(mvy));
         wall_any = 1'b1;
      end
      if (36'(my) + rad_s > WALL) begin
         my = sat16(WALL - rad_s);
         mvy = sat16(-36'(mvy));
         wall_any = 1'b1;
      end
   end

   assign msum     = {1'b0, w_ff.mi} + {1'b0, w_ff.ej.mass};
   assign approach = 35'(w_ff.pxx) + 35'(w_ff.pyy);

   // Sequencer: one request at a time, one other disc at a time.
   always_comb begin
      state_in = state_ff;
      w_in     = w_ff;
      wr       = '0;
      rd       = '0;
      div_req  = '0;
      root_req = '0;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               w_in.op   = req_data.opcode;
               w_in.slot = req_data.slot;
               w_in.j    = '0;
               w_in.hits = '0;
               w_in.wall = 1'b0;
               if (int'(req_data.slot) >= NUM_DISCS) begin
                  w_in.px  = '0;
                  w_in.py  = '0;
                  w_in.vx  = '0;
                  w_in.vy  = '0;
                  state_in = S_DONE;
               end else if (req_data.opcode == OP_WRITE) begin
                  wr.en          = 1'b1;
                  wr.addr        = ADDR_W'(req_data.slot);
                  wr.data.pos_x  = req_data.in_pos_x;
                  wr.data.pos_y  = req_data.in_pos_y;
                  wr.data.vel_x  = req_data.in_vel_x;
                  wr.data.vel_y  = req_data.in_vel_y;
                  wr.data.radius = req_data.in_radius;
                  wr.data.mass   = req_data.in_mass;
                  w_in.px  = req_data.in_pos_x;
                  w_in.py  = req_data.in_pos_y;
                  w_in.vx  = req_data.in_vel_x;
                  w_in.vy  = req_data.in_vel_y;
                  state_in = S_DONE;
               end else begin
                  rd.en    = 1'b1;
                  rd.addr  = ADDR_W'(req_data.slot);
                  state_in = S_SELF;
               end
            end
         end
         S_SELF: begin
            w_in.r  = rd_data.radius;
            w_in.mi = rd_data.mass;
            if (w_ff.op == OP_UPDATE) begin
               w_in.px   = mx;
               w_in.py   = my;
               w_in.vx   = mvx;
               w_in.vy   = mvy;
               w_in.wall = wall_any;
               state_in  = S_FETCH;
            end else begin
               w_in.px  = rd_data.pos_x;
               w_in.py  = rd_data.pos_y;
               w_in.vx  = rd_data.vel_x;
               w_in.vy  = rd_data.vel_y;
               state_in = S_DONE;
            end
         end
         S_FETCH: begin
            if (w_ff.j == (ADDR_W + 1)'(NUM_DISCS)) begin
               // Walk finished: write back the updated disc.
               wr.en          = 1'b1;
               wr.addr        = ADDR_W'(w_ff.slot);
               wr.data.pos_x  = w_ff.px;
               wr.data.pos_y  = w_ff.py;
               wr.data.vel_x  = w_ff.vx;
               wr.data.vel_y  = w_ff.vy;
               wr.data.radius = w_ff.r;
               wr.data.mass   = w_ff.mi;
               state_in       = S_DONE;
            end else if (w_ff.j == (ADDR_W + 1)'(w_ff.slot)) begin
               w_in.j = w_ff.j + 1'b1;
            end else begin
               rd.en    = 1'b1;
               rd.addr  = w_ff.j[ADDR_W-1:0];
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            w_in.ej  = rd_data;
            w_in.dx  = 17'(rd_data.pos_x) - 17'(w_ff.px);
            w_in.dy  = 17'(rd_data.pos_y) - 17'(w_ff.py);
            w_in.rvx = 17'(rd_data.vel_x) - 17'(w_ff.vx);
            w_in.rvy = 17'(rd_data.vel_y) - 17'(w_ff.vy);
            w_in.sr  = {1'b0, w_ff.r} + {1'b0, rd_data.radius};
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            w_in.dxx = 34'(w_ff.dx) * 34'(w_ff.dx);
            w_in.dyy = 34'(w_ff.dy) * 34'(w_ff.dy);
            w_in.srr = w_ff.sr * w_ff.sr;
            state_in = S_DIST;
         end
         S_DIST: begin
            w_in.d2  = 34'(w_ff.dxx) + 34'(w_ff.dyy);
            w_in.pxx = 34'(w_ff.rvx) * 34'(w_ff.dx);
            w_in.pyy = 34'(w_ff.rvy) * 34'(w_ff.dy);
            state_in = S_TEST;
         end
         S_TEST: begin
            // Skip pairs that coincide, do not overlap, have no mass or are not closing.
            if (w_ff.d2 == '0 || w_ff.d2 >= 34'(w_ff.srr) || msum == '0 ||
                !approach[34]) begin
               w_in.j   = w_ff.j + 1'b1;
               state_in = S_FETCH;
            end else begin
               root_req.start    = 1'b1;
               root_req.radicand = w_ff.d2[ROOT_IN_W-1:0];
               state_in          = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_rsp.done) begin
               w_in.len         = root_rsp.root;
               div_req.start    = 1'b1;
               div_req.dividend = (DIV_W'(mag17(w_ff.dx)) << NORM_SHIFT) +
                                  DIV_W'(root_rsp.root >> 1);
               div_req.divisor  = DIVISOR_W'(root_rsp.root);
               state_in         = S_NORM_X;
            end
         end
         S_NORM_X: begin
            if (div_rsp.done) begin
               w_in.nx = w_ff.dx[16] ? 16'(-div_rsp.quotient[15:0])
                                     : div_rsp.quotient[15:0];
               div_req.start    = 1'b1;
               div_req.dividend = (DIV_W'(mag17(w_ff.dy)) << NORM_SHIFT) +
                                  DIV_W'(w_ff.len >> 1);
               div_req.divisor  = DIVISOR_W'(w_ff.len);
               state_in         = S_NORM_Y;
            end
         end
         S_NORM_Y: begin
            if (div_rsp.done) begin
               w_in.ny = w_ff.dy[16] ? 16'(-div_rsp.quotient[15:0])
                                     : div_rsp.quotient[15:0];
               state_in = S_DOT_MUL;
            end
         end
         S_DOT_MUL: begin
            w_in.tx  = 33'(w_ff.rvx) * 33'(w_ff.nx);
            w_in.ty  = 33'(w_ff.rvy) * 33'(w_ff.ny);
            state_in = S_DOT_SUM;
         end
         S_DOT_SUM: begin
            w_in.dot = 19'(rnd_norm(36'(w_ff.tx) + 36'(w_ff.ty)));
            state_in = S_IMPULSE;
         end
         S_IMPULSE: begin
            w_in.prod_i = (36'(w_ff.dot) * 36'(signed'({1'b0, w_ff.ej.mass}))) <<< 1;
            w_in.prod_j = (36'(w_ff.dot) * 36'(signed'({1'b0, w_ff.mi}))) <<< 1;
            state_in    = S_AI_GO;
         end
         S_AI_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(mag36(w_ff.prod_i)) + DIV_W'(msum >> 1);
            div_req.divisor  = msum;
            state_in         = S_AI;
         end
         S_AI: begin
            if (div_rsp.done) begin
               w_in.ai = w_ff.prod_i[35] ? 20'(-div_rsp.quotient[19:0])
                                         : div_rsp.quotient[19:0];
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(mag36(w_ff.prod_j)) + DIV_W'(msum >> 1);
               div_req.divisor  = msum;
               state_in         = S_AJ;
            end
         end
         S_AJ: begin
            if (div_rsp.done) begin
               w_in.aj = w_ff.prod_j[35] ? 20'(-div_rsp.quotient[19:0])
                                         : div_rsp.quotient[19:0];
               state_in = S_APPLY_I;
            end
         end
         S_APPLY_I: begin
            w_in.qx  = 36'(w_ff.ai) * 36'(w_ff.nx);
            w_in.qy  = 36'(w_ff.ai) * 36'(w_ff.ny);
            state_in = S_APPLY_J;
         end
         S_APPLY_J: begin
            w_in.vx  = sat16(36'(w_ff.vx) + 36'(rnd_norm(w_ff.qx)));
            w_in.vy  = sat16(36'(w_ff.vy) + 36'(rnd_norm(w_ff.qy)));
            w_in.qx  = 36'(w_ff.aj) * 36'(w_ff.nx);
            w_in.qy  = 36'(w_ff.aj) * 36'(w_ff.ny);
            state_in = S_STORE_J;
         end
         S_STORE_J: begin
            // Write the partner back with its impulse applied.
            wr.en         = 1'b1;
            wr.addr       = w_ff.j[ADDR_W-1:0];
            wr.data       = w_ff.ej;
            wr.data.vel_x = sat16(36'(w_ff.ej.vel_x) - 36'(rnd_norm(w_ff.qx)));
            wr.data.vel_y = sat16(36'(w_ff.ej.vel_y) - 36'(rnd_norm(w_ff.qy)));
            if (w_ff.hits != '1) begin
               w_in.hits = w_ff.hits + 1'b1;
            end
            w_in.j   = w_ff.j + 1'b1;
            state_in = S_FETCH;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.out_slot  <= w_ff.slot;
         rsp_data_ff.out_pos_x <= w_ff.px;
         rsp_data_ff.out_pos_y <= w_ff.py;
         rsp_data_ff.out_vel_x <= w_ff.vx;
         rsp_data_ff.out_vel_y <= w_ff.vy;
         rsp_data_ff.hits      <= w_ff.hits;
         rsp_data_ff.wall_hit  <= w_ff.wall;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

import dcs_pkg::*;

// Scoreboard: keeps its own copy of the disc table, computes the result of
// every accepted request and checks results in order.
class collision_board;
   longint pos_x[NUM_DISCS];
   longint pos_y[NUM_DISCS];
   longint vel_x[NUM_DISCS];
   longint vel_y[NUM_DISCS];
   longint radius[NUM_DISCS];
   longint mass[NUM_DISCS];
   dcs_rsp_type pending[$];
   int mismatches;
   int checked;
   int impulse_total;
   int wall_total;

   function new();
      for (int k = 0; k < NUM_DISCS; k++) begin
         pos_x[k] = 0;
         pos_y[k] = 0;
         vel_x[k] = 0;
         vel_y[k] = 0;
         radius[k] = 0;
         mass[k] = 0;
      end
      mismatches = 0;
      checked = 0;
      impulse_total = 0;
      wall_total = 0;
   endfunction

   static function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Division rounded half away from zero; the divisor is positive.
   static function longint div_round(longint n, longint d);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   static function longint floor_root(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // Move one disc, reflect it off the walls, then resolve its collisions.
   function void advance_disc(int s, output int hits, output bit wall);
      longint one;
      longint r;
      longint mi;
      longint px;
      longint py;
      longint vx;
      longint vy;
      longint dx, dy, d2, sr, mj, msum, rvx, rvy, len, nx, ny, dot, ai, aj;
      one = 64'sd1 << FRAC_BITS;
      hits = 0;
      wall = 0;
      r = radius[s];
      mi = mass[s];
      px = clip16(pos_x[s] + vel_x[s]);
      py = clip16(pos_y[s] + vel_y[s]);
      vx = vel_x[s];
      vy = vel_y[s];
      if (px - r < -one) begin px = clip16(r - one); vx = clip16(-vx); wall = 1; end
      if (px + r > one) begin px = clip16(one - r); vx = clip16(-vx); wall = 1; end
      if (py - r < -one) begin py = clip16(r - one); vy = clip16(-vy); wall = 1; end
      if (py + r > one) begin py = clip16(one - r); vy = clip16(-vy); wall = 1; end
      pos_x[s] = px;
      pos_y[s] = py;
      for (int j = 0; j < NUM_DISCS; j++) begin
         if (j == s) continue;
         dx = pos_x[j] - px;
         dy = pos_y[j] - py;
         d2 = dx * dx + dy * dy;
         sr = r + radius[j];
         if (d2 == 0 || d2 >= sr * sr) continue;
         mj = mass[j];
         msum = mi + mj;
         if (msum == 0) continue;
         rvx = vel_x[j] - vx;
         rvy = vel_y[j] - vy;
         // Only pairs that are closing get an impulse.
         if (rvx * dx + rvy * dy >= 0) continue;
         len = floor_root(d2);
         nx = div_round(dx * 16384, len);
         ny = div_round(dy * 16384, len);
         dot = div_round(rvx * nx + rvy * ny, 16384);
         ai = div_round(2 * dot * mj, msum);
         aj = div_round(2 * dot * mi, msum);
         vx = clip16(vx + div_round(ai * nx, 16384));
         vy = clip16(vy + div_round(ai * ny, 16384));
         vel_x[j] = clip16(vel_x[j] - div_round(aj * nx, 16384));
         vel_y[j] = clip16(vel_y[j] - div_round(aj * ny, 16384));
         if (hits < 63) hits++;
      end
      vel_x[s] = vx;
      vel_y[s] = vy;
   endfunction

   // Note an accepted request and queue the result it must produce.
   function void note_request(dcs_req_type q);
      dcs_rsp_type e;
      int s;
      int hits;
      bit wall;
      s = q.slot;
      hits = 0;
      wall = 0;
      if (q.opcode == OP_WRITE) begin
         pos_x[s] = q.in_pos_x;
         pos_y[s] = q.in_pos_y;
         vel_x[s] = q.in_vel_x;
         vel_y[s] = q.in_vel_y;
         radius[s] = q.in_radius;
         mass[s] = q.in_mass;
      end else if (q.opcode == OP_UPDATE) begin
         advance_disc(s, hits, wall);
         impulse_total += hits;
         wall_total += wall;
      end
      e.out_slot = q.slot;
      e.out_pos_x = 16'(pos_x[s]);
      e.out_pos_y = 16'(pos_y[s]);
      e.out_vel_x = 16'(vel_x[s]);
      e.out_vel_y = 16'(vel_y[s]);
      e.hits = 6'(hits);
      e.wall_hit = wall;
      pending.push_back(e);
   endfunction

   function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endfunction

   // Compare one result with the oldest expectation.
   function void check_result(dcs_rsp_type a);
      dcs_rsp_type e;
      if (pending.size() == 0) begin
         flag("unexpected result, slot", -1, a.out_slot);
         return;
      end
      e = pending.pop_front();
      checked++;
      if (a.out_slot != e.out_slot) flag("out_slot", e.out_slot, a.out_slot);
      if (a.out_pos_x != e.out_pos_x) flag("out_pos_x", e.out_pos_x, a.out_pos_x);
      if (a.out_pos_y != e.out_pos_y) flag("out_pos_y", e.out_pos_y, a.out_pos_y);
      if (a.out_vel_x != e.out_vel_x) flag("out_vel_x", e.out_vel_x, a.out_vel_x);
      if (a.out_vel_y != e.out_vel_y) flag("out_vel_y", e.out_vel_y, a.out_vel_y);
      if (a.hits != e.hits) flag("hits", e.hits, a.hits);
      if (a.wall_hit != e.wall_hit) flag("wall_hit", e.wall_hit, a.wall_hit);
   endfunction
endclass

module tb;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dcs_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dcs_rsp_type rsp_data;

   collision_board board = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int request_count = 0;

   disc_collision_step_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Result side: random stalls, plus a long hold-off when one is asked for.
   initial begin
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   // Offer one request and wait for it to be taken.
   task automatic send_request(input dcs_req_type q);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      request_count++;
   endtask

   task automatic send_fields(input logic [1:0] op, input int s, input int px, input int py,
                              input int vx, input int vy, input int r, input int m);
      dcs_req_type q;
      q.opcode = op;
      q.slot = 6'(s);
      q.in_pos_x = 16'(px);
      q.in_pos_y = 16'(py);
      q.in_vel_x = 16'(vx);
      q.in_vel_y = 16'(vy);
      q.in_radius = 15'(r);
      q.in_mass = 16'(m);
      send_request(q);
   endtask

   function automatic int pick_pos();
      if ($urandom_range(99) < 80) return int'($urandom_range(12000)) - 6000;
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int pick_vel();
      if ($urandom_range(99) < 80) return int'($urandom_range(1200)) - 600;
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // Random request: slots crowd into a few entries so that discs overlap.
   task automatic send_random();
      int roll;
      int s;
      int r;
      int m;
      roll = $urandom_range(99);
      s = ($urandom_range(99) < 70) ? $urandom_range(11) : $urandom_range(63);
      r = $urandom_range(99);
      r = (r < 80) ? $urandom_range(5000) : (r < 90) ? $urandom_range(16384)
                                                    : $urandom_range(32767);
      m = ($urandom_range(99) < 5) ? 0 : $urandom_range(65535, 1);
      if (roll < 35)
         send_fields(OP_WRITE, s, pick_pos(), pick_pos(), pick_vel(), pick_vel(), r, m);
      else if (roll < 70)
         send_fields(OP_UPDATE, s, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 95)
         send_fields(OP_READ, s, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         send_fields(OP_SPARE, s, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Overall limit on the run.
   initial begin
      #200_000_000;
      $display("** disc_collision_step_top: FAILED **");
      $finish;
   end

   initial begin
      int waited;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, walls, collisions and odd pairs.
      send_fields(OP_UPDATE, 10, 0, 0, 0, 0, 0, 0);
      send_fields(OP_WRITE, 63, 32767, -32768, -32768, 32767, 32767, 65535);
      send_fields(OP_READ, 63, 0, 0, 0, 0, 0, 0);
      send_fields(OP_SPARE, 63, -1, -1, -1, -1, 32767, 65535);
      send_fields(OP_UPDATE, 63, 0, 0, 0, 0, 0, 0);
      send_fields(OP_UPDATE, 63, 0, 0, 0, 0, 0, 0);
      send_fields(OP_WRITE, 0, 0, 0, 0, 0, 4000, 100);
      send_fields(OP_WRITE, 1, 3000, 0, -2000, 0, 4000, 300);
      send_fields(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_READ, 1, 0, 0, 0, 0, 0, 0);
      send_fields(OP_WRITE, 2, -9000, 9000, 0, 0, 3000, 0);
      send_fields(OP_WRITE, 3, -9000, 9000, 100, 0, 100, 0);
      send_fields(OP_WRITE, 4, -8500, 9000, -500, 0, 2000, 0);
      send_fields(OP_UPDATE, 2, 0, 0, 0, 0, 0, 0);
      send_fields(OP_WRITE, 5, -16000, 16000, -32768, 32767, 2000, 1);
      send_fields(OP_UPDATE, 5, 0, 0, 0, 0, 0, 0);
      send_fields(OP_WRITE, 6, 100, 100, 32767, -32768, 10, 65535);
      send_fields(OP_UPDATE, 6, 0, 0, 0, 0, 0, 0);
      send_fields(OP_READ, 4, 0, 0, 0, 0, 0, 0);

      // Random phases with different idling on each side.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 49; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 49; end
            3: begin idle_pct = 20; stall_pct = 20; end
            default: begin idle_pct = $urandom_range(30); stall_pct = $urandom_range(30); end
         endcase
         // Long receiver hold-off while requests keep coming.
         if (phase == 0) hold_cycles = 2000;
         repeat (226) send_random();
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      waited = 0;
      while (board.pending.size() != 0 && waited < 200_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (400) @(posedge clock);

      $display("Sent %0d requests, checked %0d results; %0d impulses and %0d wall updates.",
               request_count, board.checked, board.impulse_total, board.wall_total);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("** disc_collision_step_top: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("** disc_collision_step_top: FAILED **");
      end
      $finish;
   end
endmodule
